[design/mfap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_pkg
// Shared types and constants of the max-flow augmenting path block.
// ----------------------------------------------------------------------------
package mfap_pkg;

    localparam int MAX_NODES_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    // 1000.0 in Q16.16
    localparam int CAP_RAW        = 65536000;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_WR_FWD = 3'd0;
    localparam mode_t MODE_WR_REV = 3'd1;
    localparam mode_t MODE_RUN    = 3'd2;
    localparam mode_t MODE_RD_FWD = 3'd3;
    localparam mode_t MODE_RD_REV = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        mode_t              mode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] entry_value;
        logic [3:0]         source_node;
        logic [3:0]         sink_node;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] result_value;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_READ_DONE,
        OP_SEARCH_INIT,
        OP_POP,
        OP_POP_WAIT,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_AUG_INIT,
        OP_WALK_INIT,
        OP_WALK_PAR,
        OP_WALK_PWAIT,
        OP_WALK_RD,
        OP_MIN_EV,
        OP_UPD_EV,
        OP_UPD_REV,
        OP_FLOW_ADD,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        KIND_LOCAL,
        KIND_READ,
        KIND_RUN
    } in_kind_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        in_kind_t kind;
        logic     clear_last;
        logic     stack_empty;
        logic     scan_take;
        logic     at_sink;
        logic     at_source;
        logic     fwd_pos;
    } dp_status_t;

endpackage

[design/mfap_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_ctrl
// Sequencer for load, read and run items; drives the datapath one op a cycle.
// ----------------------------------------------------------------------------
module mfap_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  mfap_pkg::dp_status_t status,
    output mfap_pkg::dp_cmd_t   cmd
);
    import mfap_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_INIT,
        S_POP,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_AUG,
        S_MPAR,
        S_MPWAIT,
        S_MRD,
        S_MEV,
        S_UPAR,
        S_UPWAIT,
        S_URD,
        S_UEV,
        S_UREV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op         = OP_NONE;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        accept         = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                accept   = in_valid && in_ready;
                if (accept)
                begin
                    cmd.op = OP_ACCEPT;
                    unique case (status.kind)
                        KIND_LOCAL: out_valid_next = 1'b1;
                        KIND_READ:  state_next = S_READ;
                        KIND_RUN:   state_next = S_INIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.op         = OP_READ_DONE;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_INIT:
            begin
                cmd.op     = OP_SEARCH_INIT;
                state_next = S_POP;
            end
            S_POP:
            begin
                if (status.stack_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cmd.op     = OP_POP_WAIT;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                cmd.op     = OP_SCAN_RD;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.op = OP_SCAN_EV;
                if (status.scan_take && status.at_sink)
                begin
                    state_next = S_AUG;
                end
                else if (status.at_sink)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_AUG:
            begin
                cmd.op     = OP_AUG_INIT;
                state_next = S_MPAR;
            end
            // first walk: path minimum
            S_MPAR:
            begin
                if (status.at_source)
                begin
                    cmd.op     = OP_WALK_INIT;
                    state_next = S_UPAR;
                end
                else
                begin
                    cmd.op     = OP_WALK_PAR;
                    state_next = S_MPWAIT;
                end
            end
            S_MPWAIT:
            begin
                cmd.op     = OP_WALK_PWAIT;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                cmd.op     = OP_WALK_RD;
                state_next = S_MEV;
            end
            S_MEV:
            begin
                cmd.op     = OP_MIN_EV;
                state_next = S_MPAR;
            end
            // second walk: entry updates
            S_UPAR:
            begin
                if (status.at_source)
                begin
                    cmd.op     = OP_FLOW_ADD;
                    state_next = S_INIT;
                end
                else
                begin
                    cmd.op     = OP_WALK_PAR;
                    state_next = S_UPWAIT;
                end
            end
            S_UPWAIT:
            begin
                cmd.op     = OP_WALK_PWAIT;
                state_next = S_URD;
            end
            S_URD:
            begin
                cmd.op     = OP_WALK_RD;
                state_next = S_UEV;
            end
            S_UEV:
            begin
                cmd.op     = OP_UPD_EV;
                state_next = status.fwd_pos ? S_UPAR : S_UREV;
            end
            S_UREV:
            begin
                cmd.op     = OP_UPD_REV;
                state_next = S_UPAR;
            end
            S_FINISH:
            begin
                cmd.op         = OP_FINISH;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result slot must be free whenever a late result gets loaded
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !out_valid_reg)
        else $error("read result would overwrite a pending item");

    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH |-> !out_valid_reg)
        else $error("run result would overwrite a pending item");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.kind != KIND_LOCAL) |=> !out_valid_reg)
        else $error("result shown before read or run finished");

endmodule

[design/mfap_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfap_dp
// Capacity matrices, search stack, parent links and flow arithmetic.
// ----------------------------------------------------------------------------
module mfap_dp #(
    parameter int MAX_NODES  = mfap_pkg::MAX_NODES_DEF,
    parameter int VALUE_BITS = mfap_pkg::VALUE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfap_pkg::in_item_t   in_item,
    input  mfap_pkg::dp_cmd_t    cmd,
    output mfap_pkg::dp_status_t status,
    output mfap_pkg::out_item_t  out_item
);
    import mfap_pkg::*;

    localparam int NODE_BITS  = $clog2(MAX_NODES);
    localparam int NODE_COUNT = 1 << NODE_BITS;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int DEPTH      = 1 << ADDR_BITS;
    localparam int SP_BITS    = NODE_BITS + 1;
    localparam int WIDE       = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 1;

    typedef logic [NODE_BITS-1:0]         node_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [SP_BITS-1:0]           sp_t;
    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic signed [WIDE-1:0]       wide_t;

    localparam val_t  VMAX_V   = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam val_t  VMIN_V   = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam wide_t VMAX_W   = WIDE'(VMAX_V);
    localparam wide_t VMIN_W   = WIDE'(VMIN_V);
    localparam wide_t I32MAX_W = WIDE'(32'sh7FFFFFFF);
    localparam wide_t I32MIN_W = WIDE'(-32'sh7FFFFFFF - 32'sd1);
    localparam wide_t CAP_W    = WIDE'(CAP_RAW);
    localparam val_t  AMT_INIT = (CAP_W < VMAX_W) ? val_t'(CAP_W) : VMAX_V;
    localparam sp_t   SP_FULL  = SP_BITS'(MAX_NODES);

    function automatic val_t sat_add(val_t a, val_t b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
        begin
            return s[VALUE_BITS] ? VMIN_V : VMAX_V;
        end
        return val_t'(s[VALUE_BITS-1:0]);
    endfunction

    function automatic val_t clamp_in(logic signed [31:0] x);
        wide_t xw;
        xw = WIDE'(x);
        if (xw > VMAX_W)
        begin
            return VMAX_V;
        end
        if (xw < VMIN_W)
        begin
            return VMIN_V;
        end
        return val_t'(xw);
    endfunction

    function automatic logic signed [31:0] clamp_out(val_t x);
        wide_t xw;
        xw = WIDE'(x);
        if (xw > I32MAX_W)
        begin
            return 32'sh7FFFFFFF;
        end
        if (xw < I32MIN_W)
        begin
            return -32'sh7FFFFFFF - 32'sd1;
        end
        return 32'(xw);
    endfunction

    // memories
    val_t  fwd_mem [DEPTH];
    val_t  rev_mem [DEPTH];
    node_t par_mem [NODE_COUNT];
    node_t stk_mem [NODE_COUNT];

    logic  fwd_we, rev_we, par_we, stk_we;
    addr_t fwd_waddr, rev_waddr, fwd_raddr, rev_raddr;
    val_t  fwd_wdata, rev_wdata;
    node_t par_waddr, par_wdata, par_raddr, stk_waddr, stk_wdata, stk_raddr;
    val_t  fwd_rd_reg, rev_rd_reg;
    node_t par_rd_reg, stk_rd_reg;

    // control state
    addr_t                 clr_reg, clr_next;
    sp_t                   sp_reg, sp_next;
    logic [NODE_COUNT-1:0] visited_reg, visited_next;

    // payload state
    mode_t     mode_reg, mode_next;
    logic      inside_reg, inside_next;
    node_t     s_reg, s_next, t_reg, t_next;
    node_t     f_reg, f_next, v_reg, v_next, u_reg, u_next;
    val_t      amount_reg, amount_next, flow_reg, flow_next;
    out_item_t out_reg, out_next;

    logic  in_inside, run_bad, take, fwd_pos;
    addr_t in_addr;
    val_t  edge_val;

    assign in_inside = (32'(in_item.row) < MAX_NODES) && (32'(in_item.col) < MAX_NODES);
    assign in_addr   = {node_t'(in_item.row), node_t'(in_item.col)};
    assign run_bad   = (in_item.source_node > in_item.sink_node)
                    || (32'(in_item.sink_node) >= MAX_NODES);
    assign fwd_pos   = fwd_rd_reg > 0;
    assign take      = !visited_reg[v_reg] && (fwd_pos || rev_rd_reg > 0);
    assign edge_val  = fwd_pos ? fwd_rd_reg : rev_rd_reg;

    always_comb
    begin
        if (in_item.mode == MODE_RUN && !run_bad)
        begin
            status.kind = KIND_RUN;
        end
        else if (in_item.mode == MODE_RD_FWD || in_item.mode == MODE_RD_REV)
        begin
            status.kind = KIND_READ;
        end
        else
        begin
            status.kind = KIND_LOCAL;
        end
        status.clear_last  = &clr_reg;
        status.stack_empty = sp_reg == '0;
        status.scan_take   = take;
        status.at_sink     = v_reg == t_reg;
        status.at_source   = v_reg == s_reg;
        status.fwd_pos     = fwd_pos;
    end

    assign out_item = out_reg;

    always_comb
    begin
        fwd_we       = 1'b0;
        rev_we       = 1'b0;
        par_we       = 1'b0;
        stk_we       = 1'b0;
        fwd_waddr    = {u_reg, v_reg};
        rev_waddr    = {v_reg, u_reg};
        fwd_wdata    = '0;
        rev_wdata    = '0;
        fwd_raddr    = {u_reg, v_reg};
        rev_raddr    = {v_reg, u_reg};
        par_waddr    = v_reg;
        par_wdata    = f_reg;
        par_raddr    = v_reg;
        stk_waddr    = node_t'(sp_reg);
        stk_wdata    = v_reg;
        stk_raddr    = node_t'(sp_reg - 1'b1);
        clr_next     = clr_reg;
        sp_next      = sp_reg;
        visited_next = visited_reg;
        mode_next    = mode_reg;
        inside_next  = inside_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        f_next       = f_reg;
        v_next       = v_reg;
        u_next       = u_reg;
        amount_next  = amount_reg;
        flow_next    = flow_reg;
        out_next     = out_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_CLEAR:
            begin
                fwd_we    = 1'b1;
                rev_we    = 1'b1;
                fwd_waddr = clr_reg;
                rev_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            OP_ACCEPT:
            begin
                mode_next   = in_item.mode;
                inside_next = in_inside;
                s_next      = node_t'(in_item.source_node);
                t_next      = node_t'(in_item.sink_node);
                flow_next   = '0;
                fwd_raddr   = in_addr;
                rev_raddr   = in_addr;
                out_next.status = (in_item.mode == MODE_RUN && run_bad)
                                ? STATUS_REFUSED : STATUS_OK;
                out_next.result_value = '0;
                if (in_item.mode == MODE_WR_FWD && in_inside)
                begin
                    fwd_we    = 1'b1;
                    fwd_waddr = in_addr;
                    fwd_wdata = clamp_in(in_item.entry_value);
                end
                if (in_item.mode == MODE_WR_REV && in_inside)
                begin
                    rev_we    = 1'b1;
                    rev_waddr = in_addr;
                    rev_wdata = clamp_in(in_item.entry_value);
                end
            end
            OP_READ_DONE:
            begin
                out_next.status = STATUS_OK;
                if (!inside_reg)
                begin
                    out_next.result_value = '0;
                end
                else if (mode_reg == MODE_RD_FWD)
                begin
                    out_next.result_value = clamp_out(fwd_rd_reg);
                end
                else
                begin
                    out_next.result_value = clamp_out(rev_rd_reg);
                end
            end
            OP_SEARCH_INIT:
            begin
                visited_next = NODE_COUNT'(1) << s_reg;
                stk_we       = 1'b1;
                stk_waddr    = '0;
                stk_wdata    = s_reg;
                sp_next      = SP_BITS'(1);
            end
            OP_POP:
            begin
                sp_next = sp_reg - 1'b1;
            end
            OP_POP_WAIT:
            begin
                f_next = stk_rd_reg;
                v_next = '0;
            end
            OP_SCAN_RD:
            begin
                fwd_raddr = {f_reg, v_reg};
                rev_raddr = {v_reg, f_reg};
            end
            OP_SCAN_EV:
            begin
                v_next = v_reg + 1'b1;
                if (take)
                begin
                    par_we                = 1'b1;
                    visited_next[v_reg]   = 1'b1;
                    if (v_reg != t_reg && sp_reg < SP_FULL)
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
            end
            OP_AUG_INIT:
            begin
                amount_next = AMT_INIT;
                v_next      = t_reg;
            end
            OP_WALK_INIT:
            begin
                v_next = t_reg;
            end
            OP_WALK_PAR:
            begin
            end
            OP_WALK_PWAIT:
            begin
                u_next = par_rd_reg;
            end
            OP_WALK_RD:
            begin
            end
            OP_MIN_EV:
            begin
                if (edge_val < amount_reg)
                begin
                    amount_next = edge_val;
                end
                v_next = u_reg;
            end
            OP_UPD_EV:
            begin
                if (fwd_pos)
                begin
                    fwd_we    = 1'b1;
                    fwd_wdata = fwd_rd_reg - amount_reg;
                    v_next    = u_reg;
                end
                else
                begin
                    // reverse edge: fetch forward entry of the back direction
                    rev_we    = 1'b1;
                    rev_wdata = rev_rd_reg - amount_reg;
                    fwd_raddr = {v_reg, u_reg};
                end
            end
            OP_UPD_REV:
            begin
                fwd_we    = 1'b1;
                fwd_waddr = {v_reg, u_reg};
                fwd_wdata = sat_add(fwd_rd_reg, amount_reg);
                v_next    = u_reg;
            end
            OP_FLOW_ADD:
            begin
                flow_next = sat_add(flow_reg, amount_reg);
            end
            OP_FINISH:
            begin
                out_next.status       = STATUS_OK;
                out_next.result_value = clamp_out(flow_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        fwd_rd_reg <= fwd_mem[fwd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rev_we)
        begin
            rev_mem[rev_waddr] <= rev_wdata;
        end
        rev_rd_reg <= rev_mem[rev_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_rd_reg <= par_mem[par_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            sp_reg      <= '0;
            visited_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            sp_reg      <= sp_next;
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        inside_reg <= inside_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        f_reg      <= f_next;
        v_reg      <= v_next;
        u_reg      <= u_next;
        amount_reg <= amount_next;
        flow_reg   <= flow_next;
        out_reg    <= out_next;
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("search stack overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_POP |-> sp_reg != '0)
        else $error("pop from empty search stack");

    a_amount_positive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FLOW_ADD |-> amount_reg > 0)
        else $error("augmenting amount not positive");

endmodule

[design/max_flow_augmenting_path_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_augmenting_path_top
// Max-flow engine over forward and reverse Q16.16 capacity matrices.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_item carries write, read and run items;
// output channel out_valid/out_ready/out_item returns one result per item.
// Both sides handshake on valid && ready; the result sits in an output
// register, so a write item is taken while the previous result still waits,
// as long as that result is taken in the same cycle.
// A write or unused-mode item answers straight from its accept, a read after
// the registered matrix read port. A run walks the matrices through one read
// port per matrix: a path search pops the stack and scans nodes 0 to sink,
// an augmentation walks the path for the minimum (parent, wait, read, evaluate
// per edge), then for the update (plus a reverse-entry step per reverse edge).
// A refused run (source above sink) answers like a write item.
// After reset both matrices are zeroed by a pass over 2^(2*clog2(MAX_NODES))
// entries (256 at 16 nodes); in_ready stays low during it.
// When the receiver stalls, the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module max_flow_augmenting_path_top #(
    parameter int MAX_NODES  = mfap_pkg::MAX_NODES_DEF,
    parameter int VALUE_BITS = mfap_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mfap_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mfap_pkg::out_item_t out_item
);
    import mfap_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mfap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mfap_dp #(
        .MAX_NODES  (MAX_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

endmodule

[sim/tb_max_flow_augmenting_path_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_flow_augmenting_path_top
// Self-checking bench for the max-flow augmenting path block.
// ----------------------------------------------------------------------------
// Writes, reads and runs are queued up front and driven in random bursts; each
// accepted item is fed to a behavioral flow solver that keeps its own copy of
// both capacity matrices, and the results it predicts are checked in order
// against the output channel, which stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_max_flow_augmenting_path_top;
    import mfap_pkg::*;

    localparam int  NODES      = MAX_NODES_DEF;
    localparam longint V_MAX   = 64'sd2147483647;
    localparam longint V_MIN   = -64'sd2147483648;
    localparam int  IDLE_LIMIT = 2000000;
    // quarter of the path cap, keeps path counts small on random graphs
    localparam int  CAP_STEP   = CAP_RAW / 4;

    typedef struct {
        bit       drain;
        in_item_t item;
    } stim_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    stim_t     stim_q[$];
    out_item_t flow_results_q[$];
    int        errors = 0;

    // solver state
    longint    fwd_cap[NODES*NODES];
    longint    rev_cap[NODES*NODES];
    int        path_parent[NODES];
    bit        node_seen[NODES];

    max_flow_augmenting_path_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > V_MAX) return V_MAX;
        if (s < V_MIN) return V_MIN;
        return s;
    endfunction

    // depth-first search, last pushed node popped first
    function automatic bit find_route(int s, int t);
        int stk[NODES];
        int cnt;
        int f;
        for (int i = 0; i <= t; i++)
        begin
            node_seen[i]   = 1'b0;
            path_parent[i] = 0;
        end
        cnt = 0;
        stk[cnt] = s;
        cnt++;
        node_seen[s] = 1'b1;
        while (cnt > 0)
        begin
            cnt--;
            f = stk[cnt];
            for (int v = 0; v <= t; v++)
            begin
                if (!node_seen[v] && (fwd_cap[f*NODES+v] > 0 || rev_cap[v*NODES+f] > 0))
                begin
                    path_parent[v] = f;
                    node_seen[v]   = 1'b1;
                    if (v == t) return 1'b1;
                    if (cnt < NODES)
                    begin
                        stk[cnt] = v;
                        cnt++;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic longint max_flow(int s, int t);
        longint flow;
        longint amt;
        longint e;
        int     v;
        int     u;
        int     guard;
        flow = 0;
        while (find_route(s, t))
        begin
            amt = CAP_RAW;
            v = t;
            guard = 0;
            while (v != s && guard < NODES)
            begin
                u = path_parent[v];
                e = (fwd_cap[u*NODES+v] > 0) ? fwd_cap[u*NODES+v] : rev_cap[v*NODES+u];
                if (e < amt) amt = e;
                v = u;
                guard++;
            end
            v = t;
            guard = 0;
            while (v != s && guard < NODES)
            begin
                u = path_parent[v];
                if (fwd_cap[u*NODES+v] > 0)
                    fwd_cap[u*NODES+v] -= amt;
                else
                begin
                    fwd_cap[v*NODES+u] = sat_sum(fwd_cap[v*NODES+u], amt);
                    rev_cap[v*NODES+u] -= amt;
                end
                v = u;
                guard++;
            end
            flow = sat_sum(flow, amt);
        end
        return flow;
    endfunction

    function automatic out_item_t solve_item(in_item_t it);
        out_item_t r;
        int idx;
        idx = it.row * NODES + it.col;
        r.status       = STATUS_OK;
        r.result_value = '0;
        case (it.mode)
            MODE_WR_FWD: fwd_cap[idx] = longint'(it.entry_value);
            MODE_WR_REV: rev_cap[idx] = longint'(it.entry_value);
            MODE_RD_FWD: r.result_value = fwd_cap[idx][31:0];
            MODE_RD_REV: r.result_value = rev_cap[idx][31:0];
            MODE_RUN:
            begin
                if (it.source_node > it.sink_node)
                    r.status = STATUS_REFUSED;
                else
                    r.result_value = 32'(max_flow(int'(it.source_node),
                                                  int'(it.sink_node)));
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_item_t mk(mode_t m, int r, int c, logic [31:0] val, int s, int t);
        in_item_t it;
        it.mode        = m;
        it.row         = 4'(r);
        it.col         = 4'(c);
        it.entry_value = val;
        it.source_node = 4'(s);
        it.sink_node   = 4'(t);
        return it;
    endfunction

    function automatic in_item_t wr(mode_t m, int r, int c, logic [31:0] val);
        return mk(m, r, c, val, $urandom_range(0, 15), $urandom_range(0, 15));
    endfunction

    function automatic in_item_t run_item(int s, int t);
        return mk(MODE_RUN, $urandom_range(0, 15), $urandom_range(0, 15), $urandom, s, t);
    endfunction

    function automatic logic [31:0] edge_amount();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return CAP_STEP * $urandom_range(1, 8);
        if (p < 80) return 32'h0;
        if (p < 92) return $urandom | 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic add_item(in_item_t it, bit drain = 1'b0);
        stim_q.push_back('{drain, it});
    endtask

    // stimulus
    initial
    begin
        int t;
        int s;
        int n;
        int total;
        for (int i = 0; i < NODES*NODES; i++)
        begin
            fwd_cap[i] = 0;
            rev_cap[i] = 0;
        end

        // entry extremes and unused modes
        add_item(wr(MODE_WR_FWD, 0, 15, 32'h7FFF_FFFF));
        add_item(wr(MODE_RD_FWD, 0, 15, $urandom));
        add_item(wr(MODE_WR_REV, 15, 0, 32'h8000_0000));
        add_item(wr(MODE_RD_REV, 15, 0, $urandom));
        add_item(wr(MODE_RD_FWD, 15, 15, $urandom));
        add_item(wr(mode_t'(3'd5), 7, 9, $urandom));
        add_item(wr(mode_t'(3'd6), 15, 15, $urandom));
        add_item(wr(mode_t'(3'd7), 0, 0, 32'hFFFF_FFFF));
        // source above sink, then source equal to sink
        add_item(run_item(3, 1));
        add_item(run_item(15, 0));
        add_item(run_item(5, 5));
        // two wide parallel paths, flow saturates
        add_item(wr(MODE_WR_FWD, 0, 1, 32'h7FFF_FFFF));
        add_item(wr(MODE_WR_FWD, 1, 3, 32'h7FFF_FFFF));
        add_item(wr(MODE_WR_FWD, 0, 2, 32'h7FFF_FFFF));
        add_item(wr(MODE_WR_FWD, 2, 3, 32'h7FFF_FFFF));
        add_item(run_item(0, 3));
        add_item(wr(MODE_RD_FWD, 0, 1, $urandom));
        // path through a reverse edge
        add_item(wr(MODE_WR_REV, 5, 4, CAP_RAW * 2));
        add_item(wr(MODE_WR_FWD, 5, 6, CAP_RAW / 2));
        add_item(run_item(4, 6));
        add_item(wr(MODE_RD_FWD, 5, 4, $urandom));
        add_item(wr(MODE_RD_REV, 5, 4, $urandom));
        add_item(run_item(0, 15));

        total = stim_q.size();
        while (total < 1600)
        begin
            t = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
            n = $urandom_range(4, 16);
            for (int i = 0; i < n; i++)
            begin
                add_item(wr($urandom_range(0, 1) ? MODE_WR_FWD : MODE_WR_REV,
                            $urandom_range(0, t), $urandom_range(0, t), edge_amount()),
                         total > 400 && i == 0 && $urandom_range(0, 9) == 0);
                total++;
            end
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0: add_item(wr(mode_t'($urandom_range(5, 7)), $urandom_range(0, 15),
                                   $urandom_range(0, 15), $urandom));
                    1, 2: add_item(wr(MODE_RD_REV, $urandom_range(0, 15),
                                      $urandom_range(0, 15), $urandom));
                    default: add_item(wr(MODE_RD_FWD, $urandom_range(0, 15),
                                         $urandom_range(0, 15), $urandom));
                endcase
                total++;
            end
            if (t < 15 && $urandom_range(0, 6) == 0)
                s = $urandom_range(t + 1, 15);
            else
                s = $urandom_range(0, t);
            add_item(run_item(s, t));
            total++;
        end

        wait (stim_q.size() == 0);
        @(posedge clk);
        while (in_valid || flow_results_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: bursts and gaps, predict on acceptance
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge clk or negedge rst_n)
    begin
        stim_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                flow_results_q.push_back(solve_item(in_item));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stim_q.size() != 0 &&
                         (!stim_q[0].drain || flow_results_q.size() == 0))
                begin
                    nxt = stim_q.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= nxt.item;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern redrawn periodically by rx_cycle, one long hold-off
    int  rx_cycle   = 0;
    int  rx_taken   = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  rx_pattern = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (out_valid && out_ready)
                rx_taken++;
            if (rx_cycle % 64 == 0)
                rx_pattern = $urandom_range(0, 2);
            if (!hold_done && rx_taken >= 200)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (rx_pattern)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (flow_results_q.size() == 0)
            begin
                $error("result with nothing expected: status %0d value %0d",
                       out_item.status, out_item.result_value);
                errors++;
            end
            else
            begin
                exp_r = flow_results_q.pop_front();
                if (out_item.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, out_item.status);
                    errors++;
                end
                if (out_item.result_value !== exp_r.result_value)
                begin
                    $error("result_value: expected %0d, got %0d",
                           exp_r.result_value, out_item.result_value);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
